// ===== sv/tsbm_pkg.sv =====
// Package for the two-stack byte machine execution unit: sizes, command codes and FSM states.
`default_nettype none
package tsbm_pkg;

	localparam int STACK_DEPTH = 256;
	localparam int IDX_W       = $clog2(STACK_DEPTH);
	localparam int CNT_W       = $clog2(STACK_DEPTH + 1);

	localparam int CMD_W       = 4;
	localparam int BYTE_W      = 8;
	localparam int IN_DATA_W   = 16;
	localparam int OUT_DATA_W  = 16;

	typedef logic [IDX_W-1:0]  idx_t;
	typedef logic [CNT_W-1:0]  cnt_t;
	typedef logic [BYTE_W-1:0] byte_t;

	typedef enum logic [CMD_W-1:0] {
		CMD_PUSH1       = 4'd0,
		CMD_POP         = 4'd1,
		CMD_TO_SECOND   = 4'd2,
		CMD_TO_FIRST    = 4'd3,
		CMD_COPY        = 4'd4,
		CMD_ADD         = 4'd5,
		CMD_NAND        = 4'd6,
		CMD_INPUT       = 4'd7,
		CMD_PRINT_ASCII = 4'd8,
		CMD_PRINT_NUM   = 4'd9,
		CMD_OPEN        = 4'd10,
		CMD_CLOSE       = 4'd11,
		CMD_EXCHANGE    = 4'd12,
		CMD_NOP         = 4'd13
	} cmd_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_TOP,
		S_SECOND,
		S_SWAP
	} state_t;

endpackage
`default_nettype wire

// ===== sv/two_stack_byte_machine_exec.sv =====
// Execution unit of a two-stack byte machine with both stacks held in synchronous memories.
//
//   channel   | direction | fields (tdata, lowest bit first)
//   ----------+-----------+-------------------------------------------------------------
//   s_*       | in        | command[3:0], input_byte[11:4], zeros[15:12]
//   m_*       | out       | print_valid[0], print_byte[8:1], jump_taken[9],
//             |           | stack_error[10], zeros[15:11]
//
// One instruction is in flight at a time. Push one, input, pop, nop, unknown codes and
// every instruction that faults or meets a halted unit finish on acceptance; moves, copy,
// print and brackets pass through S_TOP; add and nand through S_TOP and S_SECOND; exchange
// through S_TOP, S_SECOND and S_SWAP, as each stack memory has a single registered read port.
// Reset clears the counts, the halt flag and the FSM; memory contents are not cleared.
// A new instruction is accepted only when the result register is empty or drains in the
// same cycle.
`default_nettype none
module two_stack_byte_machine_exec (
	input  wire                         clk,
	input  wire                         arst_n,
	input  wire                         s_tvalid,
	output logic                        s_tready,
	input  wire [tsbm_pkg::IN_DATA_W-1:0]  s_tdata,  // command[3:0], input_byte[11:4]
	output logic                        m_tvalid,
	input  wire                         m_tready,
	output logic [tsbm_pkg::OUT_DATA_W-1:0] m_tdata  // print_valid, print_byte[7:0], jump_taken, stack_error
);
	import tsbm_pkg::*;

	state_t state_q, state_d;
	cnt_t   c1_q, c1_d, c2_q, c2_d;
	logic   halt_q, halt_d;
	cmd_t   cmd_q, cmd_d;
	byte_t  a_q, b_q;

	byte_t  first_mem  [STACK_DEPTH];
	byte_t  second_mem [STACK_DEPTH];
	byte_t  rd1, rd2;
	logic   we1, we2;
	idx_t   wa1, wa2, ra1, ra2;
	byte_t  wd1, wd2;

	logic   accept;
	logic   load;
	logic   pv, jt, se;
	byte_t  pb;
	logic   m_tvalid_q;
	logic [OUT_DATA_W-1:0] m_tdata_q;

	logic [CMD_W-1:0] cmd_in;
	byte_t  byte_in;
	cnt_t   c1m1, c1m2, c2m1;
	logic   need1_one, need1_two, need2_one, grow1, grow2, fault;

	assign cmd_in  = s_tdata[CMD_W-1:0];
	assign byte_in = s_tdata[CMD_W +: BYTE_W];
	assign c1m1    = c1_q - cnt_t'(1);
	assign c1m2    = c1_q - cnt_t'(2);
	assign c2m1    = c2_q - cnt_t'(1);

	assign s_tready = (state_q == S_IDLE) && (!m_tvalid_q || m_tready);
	assign accept   = s_tvalid && s_tready;
	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

	// Stack requirements of the incoming command.
	always_comb begin
		need1_one = 1'b0;
		need1_two = 1'b0;
		need2_one = 1'b0;
		grow1     = 1'b0;
		grow2     = 1'b0;
		case (cmd_in)
			CMD_PUSH1, CMD_INPUT: grow1 = 1'b1;
			CMD_POP, CMD_PRINT_ASCII, CMD_PRINT_NUM, CMD_OPEN, CMD_CLOSE: need1_one = 1'b1;
			CMD_TO_SECOND: begin
				need1_one = 1'b1;
				grow2     = 1'b1;
			end
			CMD_TO_FIRST: begin
				need2_one = 1'b1;
				grow1     = 1'b1;
			end
			CMD_COPY: begin
				need1_one = 1'b1;
				grow1     = 1'b1;
			end
			CMD_ADD, CMD_NAND, CMD_EXCHANGE: need1_two = 1'b1;
			default: ;
		endcase
		fault = (need1_one && c1_q < cnt_t'(1)) || (need1_two && c1_q < cnt_t'(2))
			|| (need2_one && c2_q < cnt_t'(1))
			|| (grow1 && c1_q == cnt_t'(STACK_DEPTH))
			|| (grow2 && c2_q == cnt_t'(STACK_DEPTH));
	end

	always_comb begin
		state_d = state_q;
		c1_d    = c1_q;
		c2_d    = c2_q;
		halt_d  = halt_q;
		cmd_d   = cmd_q;
		we1     = 1'b0;
		we2     = 1'b0;
		wa1     = c1_q[IDX_W-1:0];
		wa2     = c2_q[IDX_W-1:0];
		wd1     = '0;
		wd2     = '0;
		ra1     = c1m1[IDX_W-1:0];
		ra2     = c2m1[IDX_W-1:0];
		load    = 1'b0;
		pv      = 1'b0;
		pb      = '0;
		jt      = 1'b0;
		se      = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					cmd_d = cmd_t'(cmd_in);
					if (halt_q || fault) begin
						halt_d = 1'b1;
						load   = 1'b1;
						se     = 1'b1;
					end else begin
						case (cmd_in)
							CMD_PUSH1, CMD_INPUT: begin
								we1  = 1'b1;
								wd1  = (cmd_in == CMD_INPUT) ? byte_in : byte_t'(1);
								c1_d = c1_q + cnt_t'(1);
								load = 1'b1;
							end
							CMD_POP: begin
								c1_d = c1m1;
								load = 1'b1;
							end
							CMD_TO_SECOND, CMD_TO_FIRST, CMD_COPY, CMD_ADD, CMD_NAND,
							CMD_PRINT_ASCII, CMD_PRINT_NUM, CMD_OPEN, CMD_CLOSE,
							CMD_EXCHANGE: begin
								// The top entry is being read; its data arrives next cycle.
								state_d = S_TOP;
							end
							default: load = 1'b1;
						endcase
					end
				end
			end
			S_TOP: begin
				state_d = S_IDLE;
				load    = 1'b1;
				case (cmd_q)
					CMD_TO_SECOND: begin
						we2  = 1'b1;
						wd2  = rd1;
						c1_d = c1m1;
						c2_d = c2_q + cnt_t'(1);
					end
					CMD_TO_FIRST: begin
						we1  = 1'b1;
						wd1  = rd2;
						c2_d = c2m1;
						c1_d = c1_q + cnt_t'(1);
					end
					CMD_COPY: begin
						we1  = 1'b1;
						wd1  = rd1;
						c1_d = c1_q + cnt_t'(1);
					end
					CMD_PRINT_ASCII, CMD_PRINT_NUM: begin
						pv = 1'b1;
						pb = rd1;
					end
					CMD_OPEN:  jt = (rd1 == '0);
					CMD_CLOSE: jt = (rd1 != '0);
					CMD_ADD, CMD_NAND, CMD_EXCHANGE: begin
						load    = 1'b0;
						ra1     = c1m2[IDX_W-1:0];
						state_d = S_SECOND;
					end
					default: ;
				endcase
			end
			S_SECOND: begin
				// a_q holds the top, rd1 the entry below it.
				we1 = 1'b1;
				wa1 = c1m2[IDX_W-1:0];
				if (cmd_q == CMD_EXCHANGE) begin
					wd1     = a_q;
					state_d = S_SWAP;
				end else begin
					wd1     = (cmd_q == CMD_ADD) ? byte_t'(a_q + rd1) : ~(a_q & rd1);
					c1_d    = c1m1;
					load    = 1'b1;
					state_d = S_IDLE;
				end
			end
			S_SWAP: begin
				we1     = 1'b1;
				wa1     = c1m1[IDX_W-1:0];
				wd1     = b_q;
				load    = 1'b1;
				state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			c1_q       <= '0;
			c2_q       <= '0;
			halt_q     <= 1'b0;
			m_tvalid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			c1_q    <= c1_d;
			c2_q    <= c2_d;
			halt_q  <= halt_d;
			if (load) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		cmd_q <= cmd_d;
		if (state_q == S_TOP) begin
			a_q <= rd1;
		end
		if (state_q == S_SECOND) begin
			b_q <= rd1;
		end
		if (load) begin
			m_tdata_q <= {{(OUT_DATA_W - BYTE_W - 3){1'b0}}, se, jt, pb, pv};
		end
	end

	always_ff @(posedge clk) begin
		if (we1) begin
			first_mem[wa1] <= wd1;
		end
		rd1 <= first_mem[ra1];
	end

	always_ff @(posedge clk) begin
		if (we2) begin
			second_mem[wa2] <= wd2;
		end
		rd2 <= second_mem[ra2];
	end

endmodule
`default_nettype wire
